@@ src/jcs_pkg.sv @@
package jcs_pkg;

  // scanner modes
  localparam logic [2:0] ModeOut       = 3'd0;
  localparam logic [2:0] ModeSlash     = 3'd1;
  localparam logic [2:0] ModeStr       = 3'd2;
  localparam logic [2:0] ModeEsc       = 3'd3;
  localparam logic [2:0] ModeLine      = 3'd4;
  localparam logic [2:0] ModeLineCr    = 3'd5;
  localparam logic [2:0] ModeBlock     = 3'd6;
  localparam logic [2:0] ModeBlockStar = 3'd7;

  // end-of-stream status codes
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusOpenBlock = 2'd1;
  localparam logic [1:0] StatusTrailEsc  = 2'd2;

  // characters the scanner looks for
  localparam logic [7:0] CharSlash  = 8'h2F;
  localparam logic [7:0] CharStar   = 8'h2A;
  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharLf     = 8'h0A;
  localparam logic [7:0] CharCr     = 8'h0D;

  // output queue sizing
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  // results of one accepted byte, written into the output queue
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  item0;
    out_item_t  item1;
  } push_t;

endpackage

@@ src/jcs_if.sv @@
interface jcs_in_if import jcs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface jcs_out_if import jcs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/json_comment_stripper.sv @@
// JSONC comment stripper. Bytes of a text stream enter on in_i, one per
// transfer, and the bytes that survive leave on out_o, one per transfer.
// Line comments are dropped together with the LF, CRLF or CR that ends
// them; block comments are dropped through their closing star-slash.
// Inside double-quoted strings everything passes, and a backslash escapes
// the byte after it. A slash outside a string is held until the next byte
// shows whether it opens a comment, so one input byte can give zero, one
// or two results. The byte flagged in_last always produces a final result
// with out_last set and a status (ok, open block comment, or backslash as
// the final string byte); if nothing else is kept it is a result with
// out_valid low. The mode machine decides each byte in the cycle it is
// taken, so the block accepts one byte per clock while in_i ready is high;
// results are written into a four-entry output queue that drives out_o,
// draining at one per clock while out_o is ready. in_i ready drops only
// while that queue has fewer than two free entries. Without downstream
// stalls, only bytes releasing a held slash with a second byte (two
// results) leave results waiting in the queue, and the input waits only
// once downstream stalls have let three or more results pile up there.
module json_comment_stripper import jcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  jcs_in_if.sink   in_i,
  jcs_out_if.source out_o
);

  typedef struct packed {
    logic       emit;
    logic [2:0] mode;
  } plain_t;

  // ordinary text byte outside strings and comments
  function automatic plain_t plain_byte(input logic [7:0] b);
    plain_t r;
    if (b == CharQuote) begin
      r.emit = 1'b1;
      r.mode = ModeStr;
    end else if (b == CharSlash) begin
      r.emit = 1'b0;
      r.mode = ModeSlash;
    end else begin
      r.emit = 1'b1;
      r.mode = ModeOut;
    end
    return r;
  endfunction

  logic [2:0] mode_q, mode_d;
  logic       in_acc;
  logic       space_ok;
  push_t      push;

  // scan results for the byte on the input
  logic [1:0] cnt;
  logic [7:0] slot0, slot1;
  logic       fill;
  logic [1:0] st;
  plain_t     pl;
  logic [7:0] b;
  logic       last;

  assign in_i.ready = space_ok;
  assign in_acc     = in_i.valid && in_i.ready;
  assign b          = in_i.payload.in_byte;
  assign last       = in_i.payload.in_last;

  always_comb begin
    mode_d = mode_q;
    cnt    = 2'd0;
    slot0  = '0;
    slot1  = '0;
    fill   = 1'b0;
    st     = StatusOk;
    pl     = plain_byte(b);

    case (mode_q)
      ModeOut: begin
        if (pl.emit) begin
          slot0 = b;
          cnt   = 2'd1;
        end
        mode_d = pl.mode;
      end
      ModeSlash: begin
        if (b == CharSlash) begin
          mode_d = ModeLine;
        end else if (b == CharStar) begin
          mode_d = ModeBlock;
        end else begin
          // held slash was plain text after all
          slot0 = CharSlash;
          cnt   = 2'd1;
          if (pl.emit) begin
            slot1 = b;
            cnt   = 2'd2;
          end
          mode_d = pl.mode;
        end
      end
      ModeStr: begin
        if (b == CharBslash) begin
          if (last) begin
            st = StatusTrailEsc;
          end else begin
            slot0  = b;
            cnt    = 2'd1;
            mode_d = ModeEsc;
          end
        end else begin
          slot0 = b;
          cnt   = 2'd1;
          if (b == CharQuote) begin
            mode_d = ModeOut;
          end
        end
      end
      ModeEsc: begin
        slot0  = b;
        cnt    = 2'd1;
        mode_d = ModeStr;
      end
      ModeLine: begin
        if (b == CharLf) begin
          mode_d = ModeOut;
        end else if (b == CharCr) begin
          mode_d = ModeLineCr;
        end
      end
      ModeLineCr: begin
        // an LF right after the CR belongs to the same break
        if (b == CharLf) begin
          mode_d = ModeOut;
        end else begin
          if (pl.emit) begin
            slot0 = b;
            cnt   = 2'd1;
          end
          mode_d = pl.mode;
        end
      end
      ModeBlock: begin
        if (b == CharStar) begin
          mode_d = ModeBlockStar;
        end
      end
      ModeBlockStar: begin
        if (b == CharSlash) begin
          mode_d = ModeOut;
        end else if (b != CharStar) begin
          mode_d = ModeBlock;
        end
      end
      default: begin
        mode_d = ModeOut;
      end
    endcase

    if (last) begin
      if (mode_d == ModeSlash) begin
        // slash as final byte is flushed
        if (cnt == 2'd0) begin
          slot0 = CharSlash;
        end else begin
          slot1 = CharSlash;
        end
        cnt = cnt + 2'd1;
      end else if (mode_d == ModeBlock || mode_d == ModeBlockStar) begin
        st = StatusOpenBlock;
      end
      if (cnt == 2'd0) begin
        // nothing kept: carry the end mark on an empty result
        fill = 1'b1;
        cnt  = 2'd1;
      end
      mode_d = ModeOut;
    end
  end

  always_comb begin
    push.cnt             = in_acc ? cnt : 2'd0;
    push.item0.out_byte  = slot0;
    push.item0.out_valid = !fill;
    push.item0.out_last  = last && (cnt == 2'd1);
    push.item0.status    = (last && (cnt == 2'd1)) ? st : StatusOk;
    push.item1.out_byte  = slot1;
    push.item1.out_valid = 1'b1;
    push.item1.out_last  = last;
    push.item1.status    = last ? st : StatusOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeOut;
    end else if (in_acc) begin
      mode_q <= mode_d;
    end
  end

  // result queue toward the output channel
  jcs_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_o      (out_o)
  );

`ifndef NO_ASSERTIONS
  // every stream ends with the scanner back outside strings and comments
  a_last_resets_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.payload.in_last) |=> (mode_q == ModeOut))
    else $error("mode not reset after final byte");

  // two results only come from releasing a held slash
  a_two_from_slash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (mode_q == ModeSlash))
    else $error("two results without a held slash");

  // an empty result exists only to carry the end of the stream
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.payload.out_valid) |-> out_o.payload.out_last)
    else $error("empty result that is not final");
`endif

endmodule

@@ src/jcs_out_fifo.sv @@
module jcs_out_fifo import jcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      space_ok_o,
  jcs_out_if.source out_o
);

  out_item_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic [FifoPtrW-1:0]   wr_nxt;
  logic                  pop;

  assign pop    = out_o.valid && out_o.ready;
  assign wr_nxt = wr_q + FifoPtrW'(1);

  assign wr_d  = wr_q + FifoPtrW'(push_i.cnt);
  assign rd_d  = rd_q + FifoPtrW'(pop);
  assign cnt_d = cnt_q + FifoCntW'(push_i.cnt) - FifoCntW'(pop);

  // room for the worst case of two results from the next byte
  assign space_ok_o = (cnt_q <= FifoCntW'(FifoDepth - 2));

  assign out_o.valid   = (cnt_q != '0);
  assign out_o.payload = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.item0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.item1;
    end
  end

endmodule
